>>> rtl/ofd_pkg.sv
// shared types and constants of the optical flow frame deframer
package ofd_pkg;

    localparam logic [7:0] START_BYTE  = 8'hFE;
    localparam logic [7:0] LEN_BYTE    = 8'h0A;
    localparam logic [7:0] END_BYTE    = 8'h55;
    localparam int         PAYLOAD_LEN = 10;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
    localparam logic [1:0] STATUS_BAD_END  = 2'd2;

    typedef struct packed {
        logic        [1:0]  frame_status;
        logic signed [15:0] x_flow;
        logic signed [15:0] y_flow;
        logic        [15:0] integration_time;
        logic        [15:0] ground_distance;
        logic        [7:0]  quality_status;
        logic        [7:0]  firmware_version;
    } result_t;

endpackage

>>> rtl/ofd_parser.sv
// byte-serial frame parser: phase tracking, payload capture, checksum and decode
module ofd_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_accept,
    input  logic [7:0]      rx_byte,
    input  logic            res_blocked,
    output logic            byte_stall,
    output logic            res_load,
    output ofd_pkg::result_t res
);

    localparam logic [3:0] PH_HUNT = 4'd0;
    localparam logic [3:0] PH_LEN  = 4'd1;
    localparam logic [3:0] PH_PAY0 = 4'd2;
    localparam logic [3:0] PH_PAY9 = 4'd11;
    localparam logic [3:0] PH_CSUM = 4'd12;
    localparam logic [3:0] PH_END  = 4'd13;

    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic [7:0] csum_reg;
    logic [7:0] payload_reg [ofd_pkg::PAYLOAD_LEN];

    // only the end byte produces a result, so only it waits on the output
    assign byte_stall = (phase_reg == PH_END) && res_blocked;

    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        res_load   = 1'b0;
        if (byte_accept)
        begin
            unique case (phase_reg) inside
                PH_LEN:
                begin
                    if (rx_byte == ofd_pkg::LEN_BYTE)
                    begin
                        xor_next   = 8'h00;
                        phase_next = PH_PAY0;
                    end
                    else if (rx_byte == ofd_pkg::START_BYTE)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                [PH_PAY0:PH_PAY9]:
                begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = phase_reg + 4'd1;
                end
                PH_CSUM:
                begin
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    phase_next = PH_HUNT;
                    res_load   = 1'b1;
                end
                default:
                begin
                    // hunt, and the two unused codes behave the same
                    phase_next = (rx_byte == ofd_pkg::START_BYTE) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    // result decode, little-endian fields, zeroed on a failed frame
    always_comb
    begin
        res = '0;
        if (rx_byte != ofd_pkg::END_BYTE)
        begin
            res.frame_status = ofd_pkg::STATUS_BAD_END;
        end
        else if (xor_reg != csum_reg)
        begin
            res.frame_status = ofd_pkg::STATUS_CSUM_ERR;
        end
        else
        begin
            res.frame_status     = ofd_pkg::STATUS_OK;
            res.x_flow           = $signed({payload_reg[1], payload_reg[0]});
            res.y_flow           = $signed({payload_reg[3], payload_reg[2]});
            res.integration_time = {payload_reg[5], payload_reg[4]};
            res.ground_distance  = {payload_reg[7], payload_reg[6]};
            res.quality_status   = payload_reg[8];
            res.firmware_version = payload_reg[9];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            xor_reg   <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            for (int i = 0; i < ofd_pkg::PAYLOAD_LEN; i++)
            begin
                if (phase_reg == 4'(int'(PH_PAY0) + i))
                begin
                    payload_reg[i] <= rx_byte;
                end
            end
            if (phase_reg == PH_CSUM)
            begin
                csum_reg <= rx_byte;
            end
        end
    end

    a_end_returns_to_hunt : assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> phase_reg == PH_HUNT)
        else $error("phase did not return to hunt after a result");

    a_stall_only_on_end : assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> phase_reg == PH_END && res_blocked)
        else $error("byte stalled outside the end phase");

    // checked only on entry, the phase may sit in the first payload slot while idle
    a_payload_follows_length : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAY0 && $past(phase_reg) != PH_PAY0 |-> $past(phase_reg) == PH_LEN
            && $past(rx_byte) == ofd_pkg::LEN_BYTE)
        else $error("payload phase entered without a length byte");

endmodule

>>> rtl/optical_flow_frame_deframer_top.sv
// top level of the optical flow frame deframer
// result: valid in the cycle after its end byte transaction is accepted
// throughput: one byte per cycle; the end byte alone waits while a prior result is held
// reset: asynchronous active low, parser returns to hunting and the result register empties
// payload and checksum storage is not reset, every entry is written before it is read
module optical_flow_frame_deframer_top (
    input  logic               clk,
    input  logic               rst_n,
    // byte input channel
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    // frame result channel
    output logic               frame_valid,
    input  logic               frame_stall,
    output logic [1:0]         frame_status,
    output logic signed [15:0] x_flow,
    output logic signed [15:0] y_flow,
    output logic [15:0]        integration_time,
    output logic [15:0]        ground_distance,
    output logic [7:0]         quality_status,
    output logic [7:0]         firmware_version
);

    logic             byte_accept;
    logic             res_blocked;
    logic             res_load;
    ofd_pkg::result_t res;
    ofd_pkg::result_t res_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    // held result that the downstream side is not taking this cycle
    assign res_blocked = out_valid_reg && frame_stall;
    assign byte_accept = rx_valid && !rx_stall;

    ofd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .res_blocked (res_blocked),
        .byte_stall  (rx_stall),
        .res_load    (res_load),
        .res         (res)
    );

    // output register: a new result replaces one leaving in the same cycle
    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!frame_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign frame_valid      = out_valid_reg;
    assign frame_status     = res_reg.frame_status;
    assign x_flow           = res_reg.x_flow;
    assign y_flow           = res_reg.y_flow;
    assign integration_time = res_reg.integration_time;
    assign ground_distance  = res_reg.ground_distance;
    assign quality_status   = res_reg.quality_status;
    assign firmware_version = res_reg.firmware_version;

    a_load_never_overwrites : assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !res_blocked)
        else $error("result loaded over a held transaction");

    a_load_shows_valid : assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> frame_valid)
        else $error("loaded result not presented");

    a_status_legal : assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> frame_status == ofd_pkg::STATUS_OK
            || frame_status == ofd_pkg::STATUS_CSUM_ERR
            || frame_status == ofd_pkg::STATUS_BAD_END)
        else $error("illegal frame status code");

    a_failed_frame_zero : assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_status != ofd_pkg::STATUS_OK |-> x_flow == 16'sd0
            && y_flow == 16'sd0 && integration_time == 16'd0 && ground_distance == 16'd0
            && quality_status == 8'd0 && firmware_version == 8'd0)
        else $error("failed frame carries nonzero fields");

endmodule
